>>> hdl/hbk_pkg.sv
// ----------------------------------------------------------------------------
// hbk_pkg: shared types and constants for the histogram top-k selector
// Holds the draw layout and the lane control bundle used by the lanes and
// the top level.
// ----------------------------------------------------------------------------
package hbk_pkg;

  localparam int NUM_W        = 6;
  localparam int NUM_PER_DRAW = 6;
  localparam int HIT_W        = $clog2(NUM_PER_DRAW + 1);
  localparam int COUNT_OUT_W  = 16;
  localparam int RANK_OUT_W   = 3;

  typedef logic [NUM_W-1:0] num_t;
  typedef num_t [NUM_PER_DRAW-1:0] draw_t;

  // Control shared by every lane in a cycle.
  typedef struct packed {
    logic inc_en;   // count the draw on the numbers bus
    logic scan_en;  // examine the bin at the scan index
    logic clr_all;  // clear every bin
  } lane_ctl_t;

endpackage

>>> hdl/hbk_lane.sv
// ----------------------------------------------------------------------------
// hbk_lane: one slice of histogram bins with its own maximum scan
// Counts draws into its bins and, during selection, walks its bins to find
// the highest count, keeping the lowest bin on ties.
// ----------------------------------------------------------------------------
module hbk_lane #(
  parameter int NUM_BINS   = 64,
  parameter int COUNT_BITS = 16,
  parameter int SLICE      = 16,
  parameter int IDX_W      = 4,
  parameter int BASE       = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hbk_pkg::lane_ctl_t    ctl,
  input  logic                  clr_one,
  input  hbk_pkg::draw_t        draw,
  input  logic [IDX_W-1:0]      scan_idx,
  output logic [COUNT_BITS-1:0] best_cnt,
  output logic [IDX_W-1:0]      best_idx
);
  import hbk_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] cells_r   [SLICE];
  logic [COUNT_BITS-1:0] cells_nxt [SLICE];
  logic [COUNT_BITS-1:0] best_cnt_r;
  logic [IDX_W-1:0]      best_idx_r;
  logic [COUNT_BITS-1:0] scan_val;

  always_comb begin
    logic [HIT_W-1:0]            hits;
    logic [COUNT_BITS+HIT_W-1:0] sum;
    for (int i = 0; i < SLICE; i++) begin
      hits = '0;
      for (int j = 0; j < NUM_PER_DRAW; j++) begin
        if (int'(draw[j]) == BASE + i) begin
          hits = hits + HIT_W'(1);
        end
      end
      sum = {{HIT_W{1'b0}}, cells_r[i]} + {{COUNT_BITS{1'b0}}, hits};
      cells_nxt[i] = cells_r[i];
      if (ctl.clr_all || (clr_one && (best_idx_r == IDX_W'(i)))) begin
        cells_nxt[i] = '0;
      end else if (ctl.inc_en && (BASE + i < NUM_BINS)) begin
        // Several equal numbers in one draw add up, then saturate.
        if (sum > {{HIT_W{1'b0}}, COUNT_MAX}) begin
          cells_nxt[i] = COUNT_MAX;
        end else begin
          cells_nxt[i] = sum[COUNT_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SLICE; i++) begin
      if (!rst_n) begin
        cells_r[i] <= '0;
      end else begin
        cells_r[i] <= cells_nxt[i];
      end
    end
  end

  assign scan_val = cells_r[scan_idx];

  // Strictly greater keeps the earliest (lowest) bin on a tie.
  always_ff @(posedge clk) begin
    if (ctl.scan_en && ((scan_idx == '0) || (scan_val > best_cnt_r))) begin
      best_cnt_r <= scan_val;
      best_idx_r <= scan_idx;
    end
  end

  assign best_cnt = best_cnt_r;
  assign best_idx = best_idx_r;

endmodule

>>> hdl/histogram_top_k_select.sv
// ----------------------------------------------------------------------------
// histogram_top_k_select: histogram of drawn numbers with top-k selection
// Counts six numbers per draw into saturating bins and, on the last draw of
// a data set, reports the PICKS most frequent numbers and clears the bins.
// ----------------------------------------------------------------------------
// Usage:
// A draw is transferred at a rising edge where start is high and busy is low.
// Its six numbers are counted at that edge. A draw without in_last_draw
// leaves busy low, so such draws can follow every cycle. A draw with
// in_last_draw set is counted too, and then the selection runs: the bins
// are split over up to four lanes, each lane scans its slice of SLICE
// bins one bin per cycle, and a merge state then picks the best lane.
// The scan and the merge run once per pick, PICKS times, and busy stays
// high through the last merge. Each result is loaded in its merge state.
// Every result is shown for one cycle with out_valid high; the receiver
// cannot stall, so each result is transferred in the cycle it is shown.
// After the last pick all bins are zero again. A synchronous reset (rst_n
// low) clears every bin and returns the block to idle.
// ----------------------------------------------------------------------------
module histogram_top_k_select #(
  parameter int NUM_BINS   = 64,
  parameter int PICKS      = 6,
  parameter int COUNT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [hbk_pkg::NUM_W-1:0]          in_first_number,
  input  logic [hbk_pkg::NUM_W-1:0]          in_second_number,
  input  logic [hbk_pkg::NUM_W-1:0]          in_third_number,
  input  logic [hbk_pkg::NUM_W-1:0]          in_fourth_number,
  input  logic [hbk_pkg::NUM_W-1:0]          in_fifth_number,
  input  logic [hbk_pkg::NUM_W-1:0]          in_sixth_number,
  input  logic                               in_last_draw,
  output logic                               out_valid,
  output logic [hbk_pkg::NUM_W-1:0]          out_picked_number,
  output logic [hbk_pkg::COUNT_OUT_W-1:0]    out_picked_count,
  output logic [hbk_pkg::RANK_OUT_W-1:0]     out_pick_rank,
  output logic                               out_last_pick
);
  import hbk_pkg::*;

  // Lane split: at least two bins per lane when NUM_BINS is 2 or more, so every scan has a real index.
  localparam int LANES  = (NUM_BINS >= 8) ? 4 : ((NUM_BINS >= 4) ? 2 : 1);
  localparam int SLICE  = (NUM_BINS + LANES - 1) / LANES;
  localparam int IDX_W  = $clog2(SLICE);
  localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int BIN_W  = $clog2(LANES * SLICE);
  localparam int RANK_W = (PICKS > 1) ? $clog2(PICKS) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_MERGE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;

  logic                        out_valid_r;
  logic [NUM_W-1:0]            out_number_r;
  logic [COUNT_OUT_W-1:0]      out_count_r;
  logic [RANK_OUT_W-1:0]       out_rank_r;
  logic                        out_last_r;

  draw_t                 draw;
  lane_ctl_t             ctl;
  logic                  accept;
  logic                  last_rank;
  logic [LANES-1:0]      clr_one;
  logic [COUNT_BITS-1:0] lane_cnt [LANES];
  logic [IDX_W-1:0]      lane_idx [LANES];
  logic [COUNT_BITS-1:0] win_cnt;
  logic [LANE_W-1:0]     win_lane;
  logic [BIN_W-1:0]      win_bin;

  assign draw[0] = in_first_number;
  assign draw[1] = in_second_number;
  assign draw[2] = in_third_number;
  assign draw[3] = in_fourth_number;
  assign draw[4] = in_fifth_number;
  assign draw[5] = in_sixth_number;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign last_rank = (rank_r == RANK_W'(PICKS - 1));

  assign ctl.inc_en  = accept;
  assign ctl.scan_en = (state_r == ST_SCAN);
  assign ctl.clr_all = (state_r == ST_MERGE) && last_rank;

  // Each lane owns a contiguous slice of bins, lane 0 the lowest numbers.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    assign clr_one[l] = (state_r == ST_MERGE) && !last_rank && (win_lane == LANE_W'(l));

    hbk_lane #(
      .NUM_BINS   (NUM_BINS),
      .COUNT_BITS (COUNT_BITS),
      .SLICE      (SLICE),
      .IDX_W      (IDX_W),
      .BASE       (l * SLICE)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .clr_one  (clr_one[l]),
      .draw     (draw),
      .scan_idx (scan_idx_r),
      .best_cnt (lane_cnt[l]),
      .best_idx (lane_idx[l])
    );
  end

  // Merge: the lower lane wins a tie, which keeps the lowest bin overall.
  always_comb begin
    win_cnt  = lane_cnt[0];
    win_lane = '0;
    for (int l = 1; l < LANES; l++) begin
      if (lane_cnt[l] > win_cnt) begin
        win_cnt  = lane_cnt[l];
        win_lane = LANE_W'(l);
      end
    end
    win_bin = BIN_W'(int'(win_lane) * SLICE + int'(lane_idx[win_lane]));
  end

  // Sequencer: a scan over the SLICE bins of each lane, then a merge, once per pick.
  always_comb begin
    state_nxt    = state_r;
    scan_idx_nxt = scan_idx_r;
    rank_nxt     = rank_r;
    case (state_r)
      ST_IDLE: begin
        scan_idx_nxt = '0;
        rank_nxt     = '0;
        if (accept && in_last_draw) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_idx_r == IDX_W'(SLICE - 1)) begin
          state_nxt = ST_MERGE;
        end else begin
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
        end
      end
      ST_MERGE: begin
        scan_idx_nxt = '0;
        if (last_rank) begin
          state_nxt = ST_IDLE;
          rank_nxt  = '0;
        end else begin
          state_nxt = ST_SCAN;
          rank_nxt  = rank_r + RANK_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_idx_r  <= '0;
      rank_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_idx_r  <= scan_idx_nxt;
      rank_r      <= rank_nxt;
      out_valid_r <= (state_r == ST_MERGE);
    end
  end

  // Result payload, loaded in the merge cycle and shown the cycle after.
  always_ff @(posedge clk) begin
    if (state_r == ST_MERGE) begin
      out_number_r <= NUM_W'(win_bin);
      out_count_r  <= COUNT_OUT_W'(win_cnt);
      out_rank_r   <= RANK_OUT_W'(rank_r);
      out_last_r   <= last_rank;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_picked_number = out_number_r;
  assign out_picked_count  = out_count_r;
  assign out_pick_rank     = out_rank_r;
  assign out_last_pick     = out_last_r;

endmodule

>>> hdl/hbk_checker.sv
// ----------------------------------------------------------------------------
// hbk_checker: port-level checks for the histogram top-k selector
// Watches the command and result ports and flags sequencing errors.
// ----------------------------------------------------------------------------
module hbk_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_last_draw,
  input logic out_valid,
  input logic out_last_pick
);

  // A draw that does not end the data set never makes the block busy.
  a_plain_draw: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_last_draw) |=> !busy)
    else $error("plain draw left the block busy");

  // The last draw of a data set always starts a selection.
  a_last_draw: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_last_draw) |=> busy)
    else $error("last draw did not start the selection");

  // Only the final pick is shown once the block is idle again.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (busy != out_last_pick))
    else $error("final pick and busy disagree");

  // Picks are separated by a scan, so two results never come back to back.
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_pick) |=> !out_valid)
    else $error("results on consecutive cycles");

endmodule

bind histogram_top_k_select hbk_checker u_hbk_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_last_draw  (in_last_draw),
  .out_valid     (out_valid),
  .out_last_pick (out_last_pick)
);
